/* rtl/twr_pkg.sv */
// Package for the text word reverser: command and status structures between
// the controller and the datapath, the controller state type and the word byte test.
// Depends on nothing.
package twr_pkg;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_DELIM = 5'b01000,
		ST_ERROR = 5'b10000
	} twr_state_t;

	typedef struct packed {
		logic wr_word;
		logic set_ovf;
		logic start;
		logic rd_issue;
		logic load_byte;
		logic load_delim;
		logic load_err;
	} twr_cmd_t;

	typedef struct packed {
		logic is_word;
		logic is_eot;
		logic ovf;
		logic halted;
		logic len_zero;
		logic len_one;
		logic len_full;
		logic eot_q;
		logic slot_free;
	} twr_status_t;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	function automatic logic is_word_byte(input logic [7:0] c);
		logic hit;
		hit = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
		      ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
		      ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
		case (c)
			8'hE9, 8'hE8, 8'hEA, 8'hE0, 8'hE2, 8'hEB, 8'hFB,
			8'hF9, 8'hEE, 8'hE7, 8'hF4, 8'hF6, 8'hFC: hit = 1'b1;
			default: ;
		endcase
		return hit;
	endfunction

endpackage

/* rtl/twr_ctrl.sv */
// Controller state machine of the text word reverser.
// Depends on twr_pkg; drives the datapath through command signals only.
module twr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  twr_pkg::twr_status_t sts,
	output twr_pkg::twr_cmd_t   cmd
);
	import twr_pkg::*;

	twr_state_t state_q;
	twr_state_t state_d;
	logic       accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !sts.halted) begin
					if (sts.is_word) begin
						if (!sts.ovf) begin
							if (sts.len_full) begin
								cmd.set_ovf = 1'b1;
							end else begin
								cmd.wr_word = 1'b1;
							end
						end
					end else if (sts.ovf) begin
						state_d = ST_ERROR;
					end else if (!sts.len_zero) begin
						cmd.start = 1'b1;
						state_d   = ST_READ;
					end else if (!sts.is_eot) begin
						cmd.start = 1'b1;
						state_d   = ST_DELIM;
					end
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.slot_free) begin
					cmd.load_byte = 1'b1;
					if (sts.len_one) begin
						state_d = sts.eot_q ? ST_IDLE : ST_DELIM;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_DELIM: begin
				if (sts.slot_free) begin
					cmd.load_delim = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_ERROR: begin
				if (sts.slot_free) begin
					cmd.load_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/twr_datapath.sv */
// Datapath of the text word reverser: word store, length count, flags and
// the output register. Depends on twr_pkg; commanded by twr_ctrl.
module twr_datapath #(
	parameter int MAX_WORD = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 kind,
	input  logic [7:0]           char_byte,
	input  twr_pkg::twr_cmd_t    cmd,
	output twr_pkg::twr_status_t sts,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [7:0]           out_byte,
	output logic                 last_of_run,
	output logic                 too_long
);
	import twr_pkg::*;

	localparam int LW = $clog2(MAX_WORD);

	logic [7:0]    store_q [MAX_WORD];
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          halted_q;
	logic [7:0]    delim_q;
	logic          eot_q;
	logic [7:0]    rdata_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_err_q;
	logic [LW-1:0] len_m1;

	assign len_m1 = len_q - LW'(1);

	assign sts.is_word   = (kind == 1'b0) && is_word_byte(char_byte);
	assign sts.is_eot    = kind;
	assign sts.ovf       = ovf_q;
	assign sts.halted    = halted_q;
	assign sts.len_zero  = (len_q == '0);
	assign sts.len_one   = (len_q == LW'(1));
	assign sts.len_full  = (len_q == LW'(MAX_WORD - 1));
	assign sts.eot_q     = eot_q;
	assign sts.slot_free = !out_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.wr_word) begin
			store_q[len_q] <= char_byte;
		end
		if (cmd.rd_issue) begin
			rdata_q <= store_q[len_m1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			delim_q <= char_byte;
			eot_q   <= kind;
		end
		if (cmd.load_byte) begin
			out_byte_q <= rdata_q;
			out_last_q <= (len_q == LW'(1)) && eot_q;
			out_err_q  <= 1'b0;
		end else if (cmd.load_delim) begin
			out_byte_q <= delim_q;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b0;
		end else if (cmd.load_err) begin
			out_byte_q <= 8'h00;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_word) begin
				len_q <= len_q + LW'(1);
			end else if (cmd.load_byte) begin
				len_q <= len_m1;
			end else if (cmd.load_err) begin
				len_q <= '0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.load_err) begin
				halted_q <= 1'b1;
			end
			if (cmd.load_byte || cmd.load_delim || cmd.load_err) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_run  = out_last_q;
	assign too_long     = out_err_q;

endmodule

/* rtl/text_word_reverser_top.sv */
// Text word reverser top level. A word byte is taken and gives no result. A delimiter after stored
// bytes stalls the input while they are read back reversed and the delimiter loaded, an end of text
// while only they are, the error while it is loaded, plus output stalls: a reversed byte needs a read
// and a load. A first result passes READ and LOAD, or DELIM or ERROR, then the output register.
// Asynchronous active-low reset clears control, length and flags; store contents stay
// undefined and are never read before written.
module text_word_reverser_top #(
	parameter int MAX_WORD = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       kind,
	input  logic [7:0] char_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       too_long
);
	import twr_pkg::*;

	twr_cmd_t    cmd;
	twr_status_t sts;

	twr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	twr_datapath #(
		.MAX_WORD (MAX_WORD)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.char_byte    (char_byte),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.too_long     (too_long)
	);

endmodule
